// File: hw/rtl/fwbb_pkg.sv
// Shared types and constants for the fetch window byte budget block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fwbb_pkg;

   localparam int MAX_INSTRS_DEF = 256;
   localparam int MAX_RESULTS    = 64;

   localparam int BUDGET_W = 7;
   localparam int LEN_W    = 9;
   localparam int SLOT_W   = 8;
   localparam int BYTES_W  = 5;
   localparam int SINK_W   = 7;
   localparam int CNT_W    = 7;
   localparam int INDEX_W  = 8;
   localparam int ITER_W   = 32;
   localparam int OPC_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [OPC_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_TICK    = 2'd1,
      OP_RESTART = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYTES_PER_CYCLE = 2'd0,
      CSR_BLOCK_LENGTH    = 2'd1,
      CSR_LOOP_ENABLE     = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // input transaction taken this cycle
      logic fetch;    // fetch the instruction at the current position
      logic finish;   // emit the final result of the current item
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic active;      // the tick may fetch at all
      logic can_go;      // budget left, block end not reached, sink not full
      logic fits;        // the size just read fits the remaining budget
      logic pend_valid;  // a fetched result waits to learn whether it is last
      logic out_free;    // the output register can take a result this cycle
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/fetch_window_byte_budget_core.sv
// Top level of the fetch window byte budget block: stream ports, controller and datapath.
// A load, restart or unknown item gives its single result through the finish state and the
// output register; a tick passes the check and evaluate states per fetch, then the finish
// state, also when a size that does not fit ends it, and tready low holds results back.
// One item at a time; each fetch reads the size memory, then compares the size with the
// budget. Reset is synchronous; the size table is not cleared and is undefined until loaded.
`default_nettype none

module fetch_window_byte_budget_core #(
   parameter int MAX_INSTRS = fwbb_pkg::MAX_INSTRS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [fwbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fwbb_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // slot[7:0], instr_bytes[12:8], sink_free[19:13], zero
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // fetched_index[7:0], iteration[39:8]
   output logic        rsp_tuser,   // valid_res[0]
   output logic        rsp_tlast
);

   fwbb_pkg::cmd_type    cmd;
   fwbb_pkg::status_type status;

   logic [fwbb_pkg::INDEX_W-1:0] rsp_index;
   logic [fwbb_pkg::ITER_W-1:0]  rsp_iteration;

   fwbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   fwbb_dpath #(
      .MAX_INSTRS (MAX_INSTRS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_opcode    (req_tuser),
      .req_slot      (req_tdata[7:0]),
      .req_bytes     (req_tdata[12:8]),
      .req_sink      (req_tdata[19:13]),
      .cmd           (cmd),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_valid_res (rsp_tuser),
      .rsp_index     (rsp_index),
      .rsp_iteration (rsp_iteration),
      .rsp_tlast     (rsp_tlast)
   );

   assign rsp_tdata = {rsp_iteration, rsp_index};

endmodule

`default_nettype wire

// File: hw/rtl/fwbb_ctrl.sv
// Controller state machine of the fetch window byte budget block.
// Depends on fwbb_pkg; drives the datapath through cmd_type and reads status_type.
`default_nettype none

module fwbb_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fwbb_pkg::OPC_W-1:0]      req_opcode,
   input  fwbb_pkg::status_type            status,
   output fwbb_pkg::cmd_type               cmd
);

   fwbb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwbb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         fwbb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_opcode == fwbb_pkg::OP_TICK) begin
                  state_in = fwbb_pkg::ST_CHECK;
               end else begin
                  state_in = fwbb_pkg::ST_FINISH;
               end
            end
         end
         fwbb_pkg::ST_CHECK: begin
            // The size memory reads the current position in this cycle.
            if (status.active && status.can_go) begin
               state_in = fwbb_pkg::ST_EVAL;
            end else begin
               state_in = fwbb_pkg::ST_FINISH;
            end
         end
         fwbb_pkg::ST_EVAL: begin
            if (!status.fits) begin
               state_in = fwbb_pkg::ST_FINISH;
            end else if (!status.pend_valid || status.out_free) begin
               cmd.fetch = 1'b1;
               state_in  = fwbb_pkg::ST_CHECK;
            end
         end
         fwbb_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = fwbb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fwbb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/fwbb_dpath.sv
// Datapath of the fetch window byte budget block: configuration registers,
// size memory, fetch position, budget and the output register. Depends on fwbb_pkg.
`default_nettype none

module fwbb_dpath #(
   parameter int MAX_INSTRS = fwbb_pkg::MAX_INSTRS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fwbb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fwbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [fwbb_pkg::OPC_W-1:0]       req_opcode,
   input  logic [fwbb_pkg::SLOT_W-1:0]      req_slot,
   input  logic [fwbb_pkg::BYTES_W-1:0]     req_bytes,
   input  logic [fwbb_pkg::SINK_W-1:0]      req_sink,
   input  fwbb_pkg::cmd_type                cmd,
   output fwbb_pkg::status_type             status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_valid_res,
   output logic [fwbb_pkg::INDEX_W-1:0]     rsp_index,
   output logic [fwbb_pkg::ITER_W-1:0]      rsp_iteration,
   output logic                             rsp_tlast
);

   localparam int PosW = $clog2(MAX_INSTRS + 1);
   localparam int IdxW = (MAX_INSTRS > 1) ? $clog2(MAX_INSTRS) : 1;

   // Configuration registers.
   logic [fwbb_pkg::BUDGET_W-1:0] cfg_bpc_ff;
   logic [fwbb_pkg::LEN_W-1:0]    cfg_len_ff;
   logic                          cfg_loop_ff;

   // Size memory, no reset.
   logic [fwbb_pkg::BYTES_W-1:0]  size_mem [MAX_INSTRS];
   logic [fwbb_pkg::BYTES_W-1:0]  size_rd_ff;

   logic [PosW-1:0]               pos_ff;
   logic [fwbb_pkg::ITER_W-1:0]   iter_ff;
   logic                          active_ff;
   logic [fwbb_pkg::BUDGET_W-1:0] budget_ff;
   logic [fwbb_pkg::CNT_W-1:0]    count_ff;
   logic [fwbb_pkg::CNT_W-1:0]    limit_ff;
   logic [PosW-1:0]               len_ff;

   logic                          pend_valid_ff;
   logic [fwbb_pkg::INDEX_W-1:0]  pend_index_ff;
   logic [fwbb_pkg::ITER_W-1:0]   pend_iter_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_vres_ff;
   logic [fwbb_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [fwbb_pkg::ITER_W-1:0]   rsp_iter_ff;
   logic                          rsp_last_ff;

   logic [PosW-1:0]               len_c;
   logic [fwbb_pkg::CNT_W-1:0]    limit_c;
   logic                          out_free;
   logic                          emit;
   logic                          is_tick;
   logic                          is_load;
   logic                          is_restart;

   assign len_c = (32'(cfg_len_ff) > MAX_INSTRS) ? PosW'(MAX_INSTRS) : PosW'(cfg_len_ff);
   assign limit_c = (32'(req_sink) > fwbb_pkg::MAX_RESULTS) ?
                    fwbb_pkg::CNT_W'(fwbb_pkg::MAX_RESULTS) : fwbb_pkg::CNT_W'(req_sink);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit = (cmd.fetch && pend_valid_ff) || cmd.finish;

   always_comb begin
      is_tick    = 1'b0;
      is_load    = 1'b0;
      is_restart = 1'b0;
      case (req_opcode)
         fwbb_pkg::OP_LOAD:    is_load    = cmd.accept;
         fwbb_pkg::OP_TICK:    is_tick    = cmd.accept;
         fwbb_pkg::OP_RESTART: is_restart = cmd.accept;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_bpc_ff  <= fwbb_pkg::BUDGET_W'(16);
         cfg_len_ff  <= fwbb_pkg::LEN_W'(1);
         cfg_loop_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            fwbb_pkg::CSR_BYTES_PER_CYCLE: cfg_bpc_ff  <= csr_wdata[fwbb_pkg::BUDGET_W-1:0];
            fwbb_pkg::CSR_BLOCK_LENGTH:    cfg_len_ff  <= csr_wdata[fwbb_pkg::LEN_W-1:0];
            fwbb_pkg::CSR_LOOP_ENABLE:     cfg_loop_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Single-port style memory: one write from a load, one registered read
   // at the current fetch position every cycle.
   always_ff @(posedge clock) begin
      if (is_load && (32'(req_slot) < MAX_INSTRS)) begin
         size_mem[IdxW'(req_slot)] <= req_bytes;
      end
      size_rd_ff <= size_mem[pos_ff[IdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         iter_ff       <= '0;
         active_ff     <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            pend_valid_ff <= 1'b0;
            count_ff      <= '0;
         end
         if (is_restart) begin
            pos_ff  <= '0;
            iter_ff <= '0;
         end
         if (is_tick) begin
            if (pos_ff >= len_c) begin
               if (cfg_loop_ff) begin
                  pos_ff    <= '0;
                  iter_ff   <= iter_ff + 1'b1;
                  active_ff <= 1'b1;
               end else begin
                  active_ff <= 1'b0;
               end
            end else begin
               active_ff <= 1'b1;
            end
         end
         if (cmd.fetch) begin
            pend_valid_ff <= 1'b1;
            pos_ff        <= pos_ff + 1'b1;
            count_ff      <= count_ff + 1'b1;
         end
         if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_tick) begin
         budget_ff <= cfg_bpc_ff;
         limit_ff  <= limit_c;
         len_ff    <= len_c;
      end else if (cmd.fetch) begin
         budget_ff <= budget_ff - fwbb_pkg::BUDGET_W'(size_rd_ff);
      end
      if (cmd.fetch) begin
         pend_index_ff <= fwbb_pkg::INDEX_W'(pos_ff);
         pend_iter_ff  <= iter_ff;
      end
   end

   // Output register: a result held here waits for the sink while work goes on.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         // A finish with nothing pending is the single no-fetch result.
         rsp_vres_ff  <= pend_valid_ff;
         rsp_index_ff <= pend_valid_ff ? pend_index_ff : '0;
         rsp_iter_ff  <= pend_valid_ff ? pend_iter_ff : '0;
         rsp_last_ff  <= cmd.finish;
      end
   end

   assign status.active     = active_ff;
   assign status.can_go     = (budget_ff != '0) && (pos_ff < len_ff) && (count_ff < limit_ff);
   assign status.fits       = (fwbb_pkg::BUDGET_W'(size_rd_ff) <= budget_ff);
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_valid_res = rsp_vres_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_iteration = rsp_iter_ff;
   assign rsp_tlast     = rsp_last_ff;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result emitted while the output register is occupied");

   a_fetch_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> (fwbb_pkg::BUDGET_W'(size_rd_ff) <= budget_ff) && (budget_ff != '0))
      else $error("fetch beyond the byte budget");

   a_fetch_sink: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> (count_ff < limit_ff) && (pos_ff < len_ff))
      else $error("fetch past the sink limit or the block end");

   a_fetch_count: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fetch count did not advance");

endmodule

`default_nettype wire
